// ----- rtl/hcbd_pkg.sv -----
// shared constants, result struct and hex digit decode for the chunked body decoder
// no dependencies
package hcbd_pkg;

  localparam int SIZE_BITS = 32;

  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;

  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic       body_end;
    logic       size_overflow;
  } hcbd_res_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] nibble;
  } hcbd_hex_t;

  // 0-9, a-f, A-F to a nibble
  function automatic hcbd_hex_t hex_decode(logic [7:0] b);
    hcbd_hex_t  h;
    logic [7:0] diff;
    h.is_hex = 1'b0;
    h.nibble = 4'd0;
    diff     = 8'd0;
    if (b inside {[8'h30:8'h39]}) begin
      diff     = b - 8'h30;
      h.is_hex = 1'b1;
    end else if (b inside {[8'h61:8'h66]}) begin
      diff     = b - 8'h57;
      h.is_hex = 1'b1;
    end else if (b inside {[8'h41:8'h46]}) begin
      diff     = b - 8'h37;
      h.is_hex = 1'b1;
    end
    h.nibble = diff[3:0];
    return h;
  endfunction

endpackage

// ----- rtl/hcbd_if.sv -----
// valid/ready channel interfaces for request bytes and decoded results
// depends on nothing
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       msg_start;

  modport source (output valid, output in_byte, output msg_start, input ready);
  modport sink   (input valid, input in_byte, input msg_start, output ready);
endinterface

interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       body_end;
  logic       size_overflow;

  modport source (output valid, output out_byte, output body_end, output size_overflow,
                  input ready);
  modport sink   (input valid, input out_byte, input body_end, input size_overflow,
                  output ready);
endinterface

// ----- rtl/hcbd_parser.sv -----
// parser state and per-byte update for the chunked body decoder
// depends on hcbd_pkg
module hcbd_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         in_byte,
  input  logic               msg_start,
  output hcbd_pkg::hcbd_res_t res
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SIZE,
    PH_GAP_SIZE,
    PH_DATA,
    PH_GAP_DATA,
    PH_DONE,
    PH_HALT
  } phase_t;

  localparam logic [1:0] SKIP_AFTER_SIZE = 2'd1;
  localparam logic [1:0] SKIP_AFTER_DATA = 2'd2;
  localparam logic [1:0] HDR_LAST        = 2'd3;

  phase_t                         phase_r, phase_nxt;
  logic [1:0]                     crlf_r, crlf_nxt;
  logic [hcbd_pkg::SIZE_BITS-1:0] cnt_r, cnt_nxt;
  logic [1:0]                     skip_r, skip_nxt;

  phase_t                         ph_cur;
  logic [1:0]                     crlf_cur;
  logic [hcbd_pkg::SIZE_BITS-1:0] cnt_cur;
  logic [hcbd_pkg::SIZE_BITS-1:0] cnt_dec;
  logic [1:0]                     skip_cur;
  logic [1:0]                     skip_dec;
  logic [7:0]                     want;
  hcbd_pkg::hcbd_hex_t            hex;

  always_comb begin
    // msg_start restarts the parser before this byte
    ph_cur   = msg_start ? PH_HEADER : phase_r;
    crlf_cur = msg_start ? 2'd0 : crlf_r;
    cnt_cur  = msg_start ? '0 : cnt_r;
    skip_cur = msg_start ? 2'd0 : skip_r;

    hex      = hcbd_pkg::hex_decode(in_byte);
    want     = crlf_cur[0] ? hcbd_pkg::BYTE_LF : hcbd_pkg::BYTE_CR;
    cnt_dec  = (cnt_cur != '0) ? cnt_cur - 1'b1 : cnt_cur;
    skip_dec = (skip_cur != 2'd0) ? skip_cur - 2'd1 : skip_cur;

    phase_nxt = ph_cur;
    crlf_nxt  = crlf_cur;
    cnt_nxt   = cnt_cur;
    skip_nxt  = skip_cur;
    res       = '0;

    case (ph_cur)
      PH_HEADER: begin
        if (in_byte == want) begin
          if (crlf_cur == HDR_LAST) begin
            crlf_nxt  = 2'd0;
            cnt_nxt   = '0;
            phase_nxt = PH_SIZE;
          end else begin
            crlf_nxt = crlf_cur + 2'd1;
          end
        end else begin
          crlf_nxt = (in_byte == hcbd_pkg::BYTE_CR) ? 2'd1 : 2'd0;
        end
      end
      PH_SIZE: begin
        if (hex.is_hex) begin
          // top nibble already in use means the next digit will not fit
          if (cnt_cur[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
            phase_nxt         = PH_HALT;
            res.emit          = 1'b1;
            res.size_overflow = 1'b1;
          end else begin
            cnt_nxt = {cnt_cur[hcbd_pkg::SIZE_BITS-5:0], hex.nibble};
          end
        end else if (cnt_cur == '0) begin
          phase_nxt    = PH_DONE;
          res.emit     = 1'b1;
          res.body_end = 1'b1;
        end else begin
          skip_nxt  = SKIP_AFTER_SIZE;
          phase_nxt = PH_GAP_SIZE;
        end
      end
      PH_GAP_SIZE: begin
        skip_nxt = skip_dec;
        if (skip_dec == 2'd0) begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        cnt_nxt  = cnt_dec;
        res.emit = 1'b1;
        res.data = in_byte;
        if (cnt_dec == '0) begin
          skip_nxt  = SKIP_AFTER_DATA;
          phase_nxt = PH_GAP_DATA;
        end
      end
      PH_GAP_DATA: begin
        skip_nxt = skip_dec;
        if (skip_dec == 2'd0) begin
          cnt_nxt   = '0;
          phase_nxt = PH_SIZE;
        end
      end
      default: begin
        // done or halted: bytes ignored until msg_start
        phase_nxt = ph_cur;
      end
    endcase

    if (!step) begin
      res.emit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      crlf_r  <= 2'd0;
      cnt_r   <= '0;
      skip_r  <= 2'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      crlf_r  <= crlf_nxt;
      cnt_r   <= cnt_nxt;
      skip_r  <= skip_nxt;
    end
  end

endmodule

// ----- rtl/http_chunked_body_decoder.sv -----
// top level of the chunked body decoder: input register, parser, result register
// depends on hcbd_pkg, hcbd_if (hcbd_in_if, hcbd_out_if) and hcbd_parser
//
// The decoder takes one request byte per cycle and passes on only the bytes of
// the chunked body. Header bytes are dropped until CR LF CR LF; then a hex
// chunk size is read, the terminating byte and the one after it are dropped,
// the data bytes are forwarded, two bytes after the data are dropped and the
// next size follows. A zero size gives one request with body_end set; a size
// that does not fit in the 32-bit counter gives one request with size_overflow
// set and the parser halts. Either way later bytes are ignored until a byte
// arrives with msg_start set, which restarts header matching on that byte.
// Throughput is one byte per cycle while results are taken, set by the single
// state update per byte in the parser; a byte is held in the input register,
// then its result in the result register. A waiting result holds the byte
// in the input register; one more byte can still enter while that register
// is empty, after which the input stalls until the result is taken.
module http_chunked_body_decoder (
  input  logic              clk,
  input  logic              rst_n,
  hcbd_in_if.sink           in_ch,
  hcbd_out_if.source        out_ch
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;

  // result register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_end_r;
  logic       out_ovf_r;

  logic                out_free;
  logic                s1_adv;
  logic                in_take;
  hcbd_pkg::hcbd_res_t res;

  // result slot can be loaded when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ch.ready;
  // the held byte moves on when the result slot can take whatever it makes
  assign s1_adv   = s1_valid_r && out_free;
  assign in_take  = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !s1_valid_r || out_free;

  hcbd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .in_byte   (s1_byte_r),
    .msg_start (s1_start_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r  <= in_ch.in_byte;
      s1_start_r <= in_ch.msg_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res.emit;
    end
  end

  // payload only loads when a result is made, so a waiting one holds
  always_ff @(posedge clk) begin
    if (res.emit) begin
      out_byte_r <= res.data;
      out_end_r  <= res.body_end;
      out_ovf_r  <= res.size_overflow;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_byte      = out_byte_r;
  assign out_ch.body_end      = out_end_r;
  assign out_ch.size_overflow = out_ovf_r;

  // end and overflow never come together
  a_end_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_end_r && out_ovf_r))
    else $error("body_end and size_overflow set together");

  // marker requests carry a zero byte
  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_end_r || out_ovf_r)) |-> (out_byte_r == 8'd0))
    else $error("end or overflow request with nonzero byte");

  // a held byte that cannot move on stays held
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_byte_r)))
    else $error("input register lost a byte while stalled");

  // a result is only made when its slot is free
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    res.emit |-> out_free)
    else $error("result made while output slot is full");

endmodule
